// File: hdl/fla_pkg.sv
// Package for the free list heap allocator: constants, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package fla_pkg;

    localparam int PAGE_BYTES      = 4096;
    localparam int MAX_HEAP_BYTES  = 24576;
    localparam int MIN_SPLIT_BYTES = 32;
    localparam int STORE_WORDS     = MAX_HEAP_BYTES / 8;
    localparam int IDX_W           = $clog2(STORE_WORDS);
    localparam int OFF_W           = 15;
    localparam int SZ_W            = 16;
    localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);

    localparam logic [31:0] HDR_TAG = 32'h48DA7E11;
    localparam logic [31:0] FTR_TAG = 32'hF007E2A5;

    typedef logic [OFF_W-1:0] off_t;
    typedef logic [SZ_W-1:0]  size_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_OOM     = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_WALK_START,
        DP_WALK_RD,
        DP_WALK_SIZE,
        DP_WALK_NEXT,
        DP_UL_RN,
        DP_UL_RP,
        DP_UL_A,
        DP_UL_B,
        DP_FIT_WHOLE,
        DP_FIT_SPLIT,
        DP_SPLIT_REM,
        DP_SB_H,
        DP_SB_F,
        DP_PU_1,
        DP_PU_2,
        DP_PU_3,
        DP_GROW_FIRST,
        DP_GROW_EXT,
        DP_EPI,
        DP_FR_RH,
        DP_FR_CH,
        DP_FR_CF,
        DP_FR_CN,
        DP_FR_MERGE,
        DP_FR_SETUP
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GROW,
        ST_GROW_FIRST,
        ST_GROW_EXT,
        ST_WALK_START,
        ST_WALK_RD,
        ST_WALK_SIZE,
        ST_WALK_NEXT,
        ST_UL_RN,
        ST_UL_RP,
        ST_UL_A,
        ST_UL_B,
        ST_FIT,
        ST_SPLIT_REM,
        ST_SB_H,
        ST_SB_F,
        ST_PU_1,
        ST_PU_2,
        ST_PU_3,
        ST_EPI,
        ST_FR_RH,
        ST_FR_CH,
        ST_FR_CF,
        ST_FR_CN,
        ST_FR_MERGE,
        ST_FR_SETUP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic req_zero;
        logic heap_empty;
        logic bad_ptr;
        logic grow_ok;
        logic walk_end;
        logic fits;
        logic split;
        logic hdr_ok;
        logic ftr_ok;
        logic merge_ok;
        off_t payload;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/fla_if.sv
// Handshake channels of the allocator: request item and response item.
// Depends on fla_pkg.
`default_nettype none
interface fla_req_if
    import fla_pkg::*;
();
    logic valid;
    logic ready;
    logic op;
    logic [14:0] request_size;
    logic [14:0] block_address;

    modport source (output valid, op, request_size, block_address, input ready);
    modport sink (input valid, op, request_size, block_address, output ready);
endinterface

interface fla_rsp_if
    import fla_pkg::*;
();
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [14:0] payload_address;

    modport source (output valid, status, payload_address, input ready);
    modport sink (input valid, status, payload_address, output ready);
endinterface
`default_nettype wire

// File: hdl/fla_datapath.sv
// Allocator datapath: heap word memory, list head, heap extent and working
// registers; executes one command per cycle. Depends on fla_pkg.
`default_nettype none
module fla_datapath
    import fla_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic        req_op,
    input  wire logic [14:0] req_size,
    input  wire logic [14:0] req_addr,
    output dp_stat_t         stat
);

    logic [63:0] mem [0:STORE_WORDS-1];
    logic [63:0] q_reg;

    off_t  head_reg, epi_reg;
    size_t hb_reg;
    logic  op_reg;
    logic  req_zero_reg;
    off_t  ptr_reg;
    size_t need_reg;
    off_t  h_reg, u_reg, n_reg, p_reg, b_reg, c_reg, nxt_reg;
    size_t s_reg, bs_reg, ns_reg;
    logic  a_reg;

    size_t rounded, add, new_hb, q_sz;
    logic  rd_en, wr_en;
    off_t  rd_off, wr_off;
    logic [63:0] wr_data;

    assign q_sz    = {q_reg[15:1], 1'b0};
    assign rounded = (req_size < 15'd16) ? size_t'(16)
                   : ((size_t'(req_size) + size_t'(15)) & ~size_t'(15));
    assign add     = size_t'(((need_reg >> PAGE_SHIFT) + size_t'(1)) << PAGE_SHIFT);
    assign new_hb  = hb_reg + add;

    always_comb
    begin
        stat.is_free    = op_reg;
        stat.req_zero   = req_zero_reg;
        stat.heap_empty = (hb_reg == '0);
        stat.bad_ptr    = (hb_reg == '0) || (ptr_reg[3:0] != 4'd0) ||
                          (ptr_reg < off_t'(16)) || (ptr_reg >= epi_reg);
        stat.grow_ok    = (hb_reg == '0) ? (add <= size_t'(MAX_HEAP_BYTES))
                          : ({1'b0, new_hb} <= 17'(MAX_HEAP_BYTES)) && (new_hb >= hb_reg);
        stat.walk_end   = (h_reg == '0);
        stat.fits       = (s_reg >= need_reg);
        stat.split      = ((s_reg - need_reg) >= size_t'(MIN_SPLIT_BYTES));
        stat.hdr_ok     = q_reg[0] && (q_reg[63:32] == HDR_TAG) && (q_reg[31:16] == '0) &&
                          (q_sz >= size_t'(32)) && (q_sz[3:0] == 4'd0) &&
                          ((size_t'(h_reg) + q_sz) <= size_t'(epi_reg));
        stat.ftr_ok     = q_reg[0] && (q_reg[63:32] == FTR_TAG) && (q_reg[31:16] == '0) &&
                          (q_sz == s_reg);
        stat.merge_ok   = !q_reg[0] && (q_reg[63:32] == HDR_TAG) && (q_reg[31:16] == '0) &&
                          (q_sz >= size_t'(32)) &&
                          ((size_t'(nxt_reg) + q_sz) <= size_t'(epi_reg));
        stat.payload    = h_reg + off_t'(8);
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_off  = h_reg;
        wr_en   = 1'b0;
        wr_off  = '0;
        wr_data = '0;
        case (cmd.op)
            DP_WALK_RD:
            begin
                rd_en = 1'b1;
            end
            DP_WALK_SIZE:
            begin
                rd_en  = 1'b1;
                rd_off = h_reg + off_t'(8);
            end
            DP_UL_RN:
            begin
                rd_en  = 1'b1;
                rd_off = u_reg + off_t'(8);
            end
            DP_UL_RP:
            begin
                rd_en  = 1'b1;
                rd_off = u_reg + off_t'(16);
            end
            DP_UL_A:
            begin
                wr_en   = (q_reg[OFF_W-1:0] != '0);
                wr_off  = q_reg[OFF_W-1:0] + off_t'(8);
                wr_data = 64'(n_reg);
            end
            DP_UL_B:
            begin
                wr_en   = (n_reg != '0);
                wr_off  = n_reg + off_t'(16);
                wr_data = 64'(p_reg);
            end
            DP_SB_H:
            begin
                wr_en   = 1'b1;
                wr_off  = b_reg;
                wr_data = {HDR_TAG, 16'd0, bs_reg[15:1], a_reg};
            end
            DP_SB_F:
            begin
                wr_en   = 1'b1;
                wr_off  = OFF_W'(size_t'(b_reg) + bs_reg - size_t'(8));
                wr_data = {FTR_TAG, 16'd0, bs_reg[15:1], a_reg};
            end
            DP_PU_1:
            begin
                wr_en   = 1'b1;
                wr_off  = c_reg + off_t'(8);
                wr_data = 64'(head_reg);
            end
            DP_PU_2:
            begin
                wr_en   = 1'b1;
                wr_off  = c_reg + off_t'(16);
                wr_data = '0;
            end
            DP_PU_3:
            begin
                wr_en   = (head_reg != '0);
                wr_off  = head_reg + off_t'(16);
                wr_data = 64'(c_reg);
            end
            DP_GROW_FIRST:
            begin
                wr_en   = 1'b1;
                wr_off  = '0;
                wr_data = {HDR_TAG, 32'd1};
            end
            DP_EPI:
            begin
                wr_en   = 1'b1;
                wr_off  = OFF_W'(new_hb - size_t'(8));
                wr_data = {HDR_TAG, 32'd1};
            end
            DP_FR_RH:
            begin
                rd_en  = 1'b1;
                rd_off = ptr_reg - off_t'(8);
            end
            DP_FR_CH:
            begin
                rd_en  = stat.hdr_ok;
                rd_off = OFF_W'(size_t'(h_reg) + q_sz - size_t'(8));
            end
            DP_FR_CF:
            begin
                rd_en  = 1'b1;
                rd_off = OFF_W'(size_t'(h_reg) + s_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_off[OFF_W-1:3] < IDX_W'(STORE_WORDS)))
        begin
            mem[wr_off[OFF_W-1:3]] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_off[OFF_W-1:3]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            epi_reg  <= '0;
            hb_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                DP_UL_A:
                begin
                    if (q_reg[OFF_W-1:0] == '0)
                    begin
                        head_reg <= n_reg;
                    end
                end
                DP_PU_3:
                begin
                    head_reg <= c_reg;
                end
                DP_GROW_FIRST:
                begin
                    head_reg <= '0;
                end
                DP_EPI:
                begin
                    hb_reg  <= new_hb;
                    epi_reg <= OFF_W'(new_hb - size_t'(8));
                end
                default:
                begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= req_op;
            req_zero_reg <= (req_size == '0);
            ptr_reg      <= req_addr;
            need_reg     <= rounded + size_t'(16);
        end
        case (cmd.op)
            DP_WALK_START:
            begin
                h_reg <= head_reg;
            end
            DP_WALK_SIZE:
            begin
                s_reg <= q_sz;
                u_reg <= h_reg;
            end
            DP_WALK_NEXT:
            begin
                h_reg <= q_reg[OFF_W-1:0];
            end
            DP_UL_RP:
            begin
                n_reg <= q_reg[OFF_W-1:0];
            end
            DP_UL_A:
            begin
                p_reg <= q_reg[OFF_W-1:0];
            end
            DP_FIT_WHOLE:
            begin
                b_reg  <= h_reg;
                bs_reg <= s_reg;
                a_reg  <= 1'b1;
            end
            DP_FIT_SPLIT:
            begin
                b_reg  <= h_reg;
                bs_reg <= need_reg;
                a_reg  <= 1'b1;
            end
            DP_SPLIT_REM:
            begin
                b_reg  <= OFF_W'(size_t'(h_reg) + need_reg);
                c_reg  <= OFF_W'(size_t'(h_reg) + need_reg);
                bs_reg <= s_reg - need_reg;
                a_reg  <= 1'b0;
            end
            DP_GROW_FIRST:
            begin
                b_reg  <= off_t'(8);
                c_reg  <= off_t'(8);
                bs_reg <= add - size_t'(16);
                a_reg  <= 1'b0;
            end
            DP_GROW_EXT:
            begin
                b_reg  <= epi_reg;
                c_reg  <= epi_reg;
                bs_reg <= add;
                a_reg  <= 1'b0;
            end
            DP_FR_RH:
            begin
                h_reg <= ptr_reg - off_t'(8);
            end
            DP_FR_CH:
            begin
                s_reg <= q_sz;
            end
            DP_FR_CF:
            begin
                nxt_reg <= OFF_W'(size_t'(h_reg) + s_reg);
            end
            DP_FR_CN:
            begin
                ns_reg <= q_sz;
                u_reg  <= nxt_reg;
            end
            DP_FR_MERGE:
            begin
                s_reg <= s_reg + ns_reg;
            end
            DP_FR_SETUP:
            begin
                b_reg  <= h_reg;
                c_reg  <= h_reg;
                bs_reg <= s_reg;
                a_reg  <= 1'b0;
            end
            default:
            begin
                a_reg <= a_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/fla_ctrl.sv
// Allocator controller: sequencing FSM, request handshake and the result
// register. Depends on fla_pkg.
`default_nettype none
module fla_ctrl
    import fla_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output status_t       rsp_status,
    output off_t          rsp_payload,
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);

    state_t  state_reg, state_next;
    state_t  ret_reg, ret_next;
    status_t status_reg, status_next;
    logic    grow_reg, grow_next;
    logic    retry_reg, retry_next;
    logic    out_valid_reg, out_valid_next;
    status_t out_status_reg, out_status_next;
    off_t    out_pay_reg, out_pay_next;

    assign req_ready   = (state_reg == ST_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign rsp_status  = out_status_reg;
    assign rsp_payload = out_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_DONE;
            status_reg     <= STATUS_OK;
            grow_reg       <= 1'b0;
            retry_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_pay_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            status_reg     <= status_next;
            grow_reg       <= grow_next;
            retry_reg      <= retry_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_pay_reg    <= out_pay_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        status_next     = status_reg;
        grow_next       = grow_reg;
        retry_next      = retry_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_status_next = out_status_reg;
        out_pay_next    = out_pay_reg;
        cmd.load        = 1'b0;
        cmd.op          = DP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                status_next = STATUS_OK;
                retry_next  = 1'b0;
                grow_next   = 1'b0;
                if (stat.is_free)
                begin
                    if (stat.bad_ptr)
                    begin
                        status_next = STATUS_INVALID;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_FR_RH;
                    end
                end
                else if (stat.req_zero)
                begin
                    status_next = STATUS_INVALID;
                    state_next  = ST_DONE;
                end
                else if (stat.heap_empty)
                begin
                    state_next = ST_GROW;
                end
                else
                begin
                    state_next = ST_WALK_START;
                end
            end
            ST_GROW:
            begin
                if (!stat.grow_ok)
                begin
                    status_next = STATUS_OOM;
                    state_next  = ST_DONE;
                end
                else
                begin
                    grow_next  = 1'b1;
                    state_next = stat.heap_empty ? ST_GROW_FIRST : ST_GROW_EXT;
                end
            end
            ST_GROW_FIRST:
            begin
                cmd.op     = DP_GROW_FIRST;
                ret_next   = ST_PU_1;
                state_next = ST_SB_H;
            end
            ST_GROW_EXT:
            begin
                cmd.op     = DP_GROW_EXT;
                ret_next   = ST_PU_1;
                state_next = ST_SB_H;
            end
            ST_EPI:
            begin
                cmd.op     = DP_EPI;
                state_next = ST_WALK_START;
            end
            ST_WALK_START:
            begin
                cmd.op     = DP_WALK_START;
                state_next = ST_WALK_RD;
            end
            ST_WALK_RD:
            begin
                if (stat.walk_end)
                begin
                    if (retry_reg)
                    begin
                        status_next = STATUS_OOM;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        retry_next = 1'b1;
                        state_next = ST_GROW;
                    end
                end
                else
                begin
                    cmd.op     = DP_WALK_RD;
                    state_next = ST_WALK_SIZE;
                end
            end
            ST_WALK_SIZE:
            begin
                cmd.op     = DP_WALK_SIZE;
                state_next = ST_WALK_NEXT;
            end
            ST_WALK_NEXT:
            begin
                if (stat.fits)
                begin
                    state_next = ST_UL_RN;
                end
                else
                begin
                    cmd.op     = DP_WALK_NEXT;
                    state_next = ST_WALK_RD;
                end
            end
            ST_UL_RN:
            begin
                cmd.op     = DP_UL_RN;
                state_next = ST_UL_RP;
            end
            ST_UL_RP:
            begin
                cmd.op     = DP_UL_RP;
                state_next = ST_UL_A;
            end
            ST_UL_A:
            begin
                cmd.op     = DP_UL_A;
                state_next = ST_UL_B;
            end
            ST_UL_B:
            begin
                cmd.op     = DP_UL_B;
                state_next = stat.is_free ? ST_FR_MERGE : ST_FIT;
            end
            ST_FIT:
            begin
                if (stat.split)
                begin
                    cmd.op   = DP_FIT_SPLIT;
                    ret_next = ST_SPLIT_REM;
                end
                else
                begin
                    cmd.op   = DP_FIT_WHOLE;
                    ret_next = ST_DONE;
                end
                state_next = ST_SB_H;
            end
            ST_SPLIT_REM:
            begin
                cmd.op     = DP_SPLIT_REM;
                ret_next   = ST_PU_1;
                state_next = ST_SB_H;
            end
            ST_SB_H:
            begin
                cmd.op     = DP_SB_H;
                state_next = ST_SB_F;
            end
            ST_SB_F:
            begin
                cmd.op     = DP_SB_F;
                state_next = ret_reg;
            end
            ST_PU_1:
            begin
                cmd.op     = DP_PU_1;
                state_next = ST_PU_2;
            end
            ST_PU_2:
            begin
                cmd.op     = DP_PU_2;
                state_next = ST_PU_3;
            end
            ST_PU_3:
            begin
                cmd.op    = DP_PU_3;
                grow_next = 1'b0;
                state_next = grow_reg ? ST_EPI : ST_DONE;
            end
            ST_FR_RH:
            begin
                cmd.op     = DP_FR_RH;
                state_next = ST_FR_CH;
            end
            ST_FR_CH:
            begin
                cmd.op = DP_FR_CH;
                if (stat.hdr_ok)
                begin
                    state_next = ST_FR_CF;
                end
                else
                begin
                    status_next = STATUS_INVALID;
                    state_next  = ST_DONE;
                end
            end
            ST_FR_CF:
            begin
                if (stat.ftr_ok)
                begin
                    cmd.op     = DP_FR_CF;
                    state_next = ST_FR_CN;
                end
                else
                begin
                    status_next = STATUS_INVALID;
                    state_next  = ST_DONE;
                end
            end
            ST_FR_CN:
            begin
                cmd.op     = DP_FR_CN;
                state_next = stat.merge_ok ? ST_UL_RN : ST_FR_SETUP;
            end
            ST_FR_MERGE:
            begin
                cmd.op     = DP_FR_MERGE;
                state_next = ST_FR_SETUP;
            end
            ST_FR_SETUP:
            begin
                cmd.op     = DP_FR_SETUP;
                ret_next   = ST_PU_1;
                state_next = ST_SB_H;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_pay_next    = (status_reg == STATUS_OK && !stat.is_free)
                                      ? stat.payload : '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/free_list_heap_allocator.sv
// Alloc: first-fit walk of the free list, unlink, header and footer; a split also
//   writes and pushes the remainder, and a zero request fails at once. A heap
//   extension adds pages and walks again. Free merges a free next block, pushes it.
// Throughput: one item at a time; a new request is taken only while the controller is idle.
// Reset: asynchronous, active low; empties the list and the heap extent.
// The heap memory is not cleared. Depends on fla_pkg, fla_if, fla_ctrl,
// fla_datapath.
`default_nettype none
module free_list_heap_allocator
    import fla_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    fla_req_if.sink   req,
    fla_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    status_t  rsp_status;
    off_t     rsp_payload;

    assign rsp.status          = rsp_status;
    assign rsp.payload_address = rsp_payload;

    fla_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_status  (rsp_status),
        .rsp_payload (rsp_payload),
        .cmd         (cmd),
        .stat        (stat)
    );

    fla_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_op   (req.op),
        .req_size (req.request_size),
        .req_addr (req.block_address),
        .stat     (stat)
    );

endmodule
`default_nettype wire

// File: hdl/fla_checker.sv
// Port-level checks for the allocator and the bind that attaches them.
// Depends on fla_pkg and free_list_heap_allocator.
`default_nettype none
module fla_checker
    import fla_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  rsp_status,
    input wire logic [14:0] rsp_payload
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_payload))
        else $error("response changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != STATUS_OK) |-> rsp_payload == '0)
        else $error("nonzero address on failure");

    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_OK) |-> rsp_payload[3:0] == 4'd0)
        else $error("misaligned payload address");

endmodule

bind free_list_heap_allocator fla_checker u_fla_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_payload (rsp.payload_address)
);
`default_nettype wire

// File: tb/testbench.sv
// Testbench for free_list_heap_allocator: directed and random alloc/free items with
// random gaps on both sides, checked against a behavioral heap model kept here.
// Depends on fla_pkg, fla_if and the allocator RTL.
`timescale 1ns / 100ps
module testbench;
    import fla_pkg::*;

    localparam int N_ITEMS     = 1600;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        op_t         op;
        logic [14:0] size;
        logic [14:0] addr;
        status_t     status;
        logic [14:0] payload;
    } heap_item_t;

    logic clk;
    logic rst_n;

    fla_req_if req ();
    fla_rsp_if rsp ();

    free_list_heap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // heap model state
    logic [63:0] heap_mem [STORE_WORDS];
    bit          heap_written [STORE_WORDS];
    int unsigned list_head;
    int unsigned heap_base;
    int unsigned epi_pos;
    int unsigned heap_len;

    heap_item_t  pending_items [$];
    heap_item_t  expected_rsp [$];
    heap_item_t  cur_item;
    int unsigned live_blocks [$];
    int unsigned freed_blocks [$];

    int          gap_left;
    int          hold_left;
    bit          hold_done;
    int          accepted_cnt;
    int          checked_cnt = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          n_ok;
    int          n_invalid;
    int          n_oom;

    function automatic logic [63:0] word_rd(int unsigned off);
        if ((off >> 3) >= STORE_WORDS)
        begin
            return 64'd0;
        end
        return heap_mem[off >> 3];
    endfunction

    function automatic void word_wr(int unsigned off, logic [63:0] v);
        if ((off >> 3) < STORE_WORDS)
        begin
            heap_mem[off >> 3] = v;
            heap_written[off >> 3] = 1'b1;
        end
    endfunction

    function automatic bit word_known(int unsigned off);
        return (off >> 3) < STORE_WORDS && heap_written[off >> 3];
    endfunction

    function automatic int unsigned size_of(logic [63:0] w);
        return w[31:0] & 32'hFFFF_FFFE;
    endfunction

    function automatic void mark_word(int unsigned off, logic [31:0] tag, int unsigned sz,
                                      bit alloc);
        word_wr(off, {tag, sz[31:1], alloc});
    endfunction

    function automatic void set_blk(int unsigned h, int unsigned sz, bit alloc);
        mark_word(h, HDR_TAG, sz, alloc);
        mark_word(h + sz - 8, FTR_TAG, sz, alloc);
    endfunction

    function automatic void unlink_blk(int unsigned h);
        int unsigned n;
        int unsigned p;
        n = 32'(word_rd(h + 8));
        p = 32'(word_rd(h + 16));
        if (p == 0)
        begin
            list_head = n;
        end
        else
        begin
            word_wr(p + 8, 64'(n));
        end
        if (n != 0)
        begin
            word_wr(n + 16, 64'(p));
        end
    endfunction

    function automatic void push_blk(int unsigned h);
        word_wr(h + 8, 64'(list_head));
        word_wr(h + 16, 64'd0);
        if (list_head != 0)
        begin
            word_wr(list_head + 16, 64'(h));
        end
        list_head = h;
    endfunction

    function automatic int unsigned fit_first(int unsigned need);
        int unsigned h;
        int unsigned s;
        h = list_head;
        for (int i = 0; i < MAX_HEAP_BYTES / 32 + 2 && h != 0; i++)
        begin
            s = size_of(word_rd(h));
            if (s >= need)
            begin
                unlink_blk(h);
                if (s - need >= MIN_SPLIT_BYTES)
                begin
                    set_blk(h, need, 1'b1);
                    set_blk(h + need, s - need, 1'b0);
                    push_blk(h + need);
                end
                else
                begin
                    set_blk(h, s, 1'b1);
                end
                return h + 8;
            end
            h = 32'(word_rd(h + 8));
        end
        return 0;
    endfunction

    function automatic bit grow_heap(int unsigned need);
        int unsigned add;
        add = (need / PAGE_BYTES + 1) * PAGE_BYTES;
        if (heap_len == 0)
        begin
            if (add > MAX_HEAP_BYTES)
            begin
                return 1'b0;
            end
            heap_base = 8;
            mark_word(0, HDR_TAG, 0, 1'b1);
            set_blk(8, add - 16, 1'b0);
            list_head = 0;
            push_blk(8);
        end
        else
        begin
            if (heap_len + add > MAX_HEAP_BYTES)
            begin
                return 1'b0;
            end
            set_blk(epi_pos, add, 1'b0);
            push_blk(epi_pos);
        end
        heap_len += add;
        epi_pos = heap_len - 8;
        mark_word(epi_pos, HDR_TAG, 0, 1'b1);
        return 1'b1;
    endfunction

    function automatic bit free_rejected_early(int unsigned ptr);
        return heap_len == 0 || (ptr & 15) != 0 || ptr < heap_base + 8 || ptr >= epi_pos;
    endfunction

    function automatic status_t free_block(int unsigned ptr);
        int unsigned h;
        int unsigned s;
        int unsigned ns;
        logic [63:0] hw;
        logic [63:0] fw;
        logic [63:0] nw;
        if (free_rejected_early(ptr))
        begin
            return STATUS_INVALID;
        end
        h = ptr - 8;
        hw = word_rd(h);
        if (!hw[0] || hw[63:32] != HDR_TAG)
        begin
            return STATUS_INVALID;
        end
        s = size_of(hw);
        if (s < 32 || (s & 15) != 0 || h + s > epi_pos)
        begin
            return STATUS_INVALID;
        end
        fw = word_rd(h + s - 8);
        if (!fw[0] || fw[63:32] != FTR_TAG || size_of(fw) != s)
        begin
            return STATUS_INVALID;
        end
        nw = word_rd(h + s);
        if (!nw[0] && nw[63:32] == HDR_TAG)
        begin
            ns = size_of(nw);
            if (ns >= 32 && h + s + ns <= epi_pos)
            begin
                unlink_blk(h + s);
                s += ns;
            end
        end
        set_blk(h, s, 1'b0);
        push_blk(h);
        return STATUS_OK;
    endfunction

    // true when freeing ptr reads only words that hold defined data
    function automatic bit free_reads_known(int unsigned ptr);
        int unsigned h;
        int unsigned s;
        logic [63:0] hw;
        logic [63:0] fw;
        if (free_rejected_early(ptr))
        begin
            return 1'b1;
        end
        h = ptr - 8;
        if (!word_known(h))
        begin
            return 1'b0;
        end
        hw = word_rd(h);
        s = size_of(hw);
        if (!hw[0] || hw[63:32] != HDR_TAG || s < 32 || (s & 15) != 0 || h + s > epi_pos)
        begin
            return 1'b1;
        end
        if (!word_known(h + s - 8))
        begin
            return 1'b0;
        end
        fw = word_rd(h + s - 8);
        if (!fw[0] || fw[63:32] != FTR_TAG || size_of(fw) != s)
        begin
            return 1'b1;
        end
        return word_known(h + s);
    endfunction

    task automatic add_item(op_t op, int unsigned size, int unsigned addr);
        heap_item_t it;
        int unsigned rounded;
        int unsigned pay;
        it.op = op;
        it.size = size[14:0];
        it.addr = addr[14:0];
        it.payload = '0;
        it.status = STATUS_OK;
        pay = 0;
        if (op == OP_FREE)
        begin
            it.status = free_block(it.addr);
        end
        else if (it.size == 0)
        begin
            it.status = STATUS_INVALID;
        end
        else
        begin
            rounded = (it.size < 16) ? 16 : ((it.size + 15) & ~32'd15);
            if (heap_len == 0 && !grow_heap(rounded + 16))
            begin
                it.status = STATUS_OOM;
            end
            else
            begin
                pay = fit_first(rounded + 16);
                if (pay == 0)
                begin
                    if (grow_heap(rounded + 16))
                    begin
                        pay = fit_first(rounded + 16);
                    end
                    if (pay == 0)
                    begin
                        it.status = STATUS_OOM;
                    end
                end
            end
        end
        if (it.status == STATUS_OK && op == OP_ALLOC)
        begin
            it.payload = pay[14:0];
            live_blocks.push_back(pay);
        end
        case (it.status)
            STATUS_OK: n_ok++;
            STATUS_INVALID: n_invalid++;
            default: n_oom++;
        endcase
        pending_items.push_back(it);
    endtask

    task automatic add_live_free();
        int idx;
        int unsigned a;
        idx = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[idx];
        live_blocks.delete(idx);
        freed_blocks.push_back(a);
        if (freed_blocks.size() > 32)
        begin
            void'(freed_blocks.pop_front());
        end
        add_item(OP_FREE, $urandom_range(32767), a);
    endtask

    task automatic add_bad_free();
        int unsigned a;
        int pick;
        pick = $urandom_range(3);
        if (pick == 0 && freed_blocks.size() > 0)
        begin
            a = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
        end
        else if (pick == 1)
        begin
            a = $urandom_range(24575) & ~32'd15;
        end
        else if (pick == 2)
        begin
            a = $urandom_range(24575);
        end
        else
        begin
            a = ($urandom_range(1535) << 4) | $urandom_range(1, 15);
        end
        if (!free_reads_known(a))
        begin
            a = a | 1;
        end
        add_item(OP_FREE, $urandom_range(32767), a);
    endtask

    function automatic int unsigned rand_size();
        int r;
        r = $urandom_range(99);
        if (r < 1)
        begin
            return 0;
        end
        else if (r < 70)
        begin
            return $urandom_range(1, 256);
        end
        else if (r < 90)
        begin
            return $urandom_range(257, 2048);
        end
        else if (r < 98)
        begin
            return $urandom_range(2049, 6000);
        end
        return $urandom_range(6001, 24576);
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.op <= OP_ALLOC;
            req.request_size <= '0;
            req.block_address <= '0;
            gap_left <= 0;
            accepted_cnt <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
            begin
                expected_rsp.push_back(cur_item);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                req.valid <= 1'b1;
                req.op <= cur_item.op;
                req.request_size <= cur_item.size;
                req.block_address <= cur_item.addr;
                gap_left <= (accepted_cnt > 700 && accepted_cnt < 900) ? 0 : rand_gap();
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // response side, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else if (accepted_cnt > 1000 && accepted_cnt < 1200)
        begin
            rsp.ready <= 1'b1;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) < 8) ? 1'b0 : (rand_gap() == 0);
        end
    end

    always @(posedge clk)
    begin
        heap_item_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("ERROR: unexpected response status=%0d payload=%0d",
                             rsp.status, rsp.payload_address);
                end
            end
            else
            begin
                e = expected_rsp.pop_front();
                if (rsp.status !== e.status || rsp.payload_address !== e.payload)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("ERROR: item %0d op=%0d size=%0d addr=%0d: exp %0d/%0d got %0d/%0d",
                                 checked_cnt, e.op, e.size, e.addr, e.status, e.payload,
                                 rsp.status, rsp.payload_address);
                    end
                end
                checked_cnt++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items pending", cycle_cnt,
                     expected_rsp.size());
            $display("FAIL free_list_heap_allocator");
            $finish;
        end
    end

    initial
    begin
        int n;
        n_ok = 0;
        n_invalid = 0;
        n_oom = 0;
        heap_len = 0;
        heap_base = 0;
        epi_pos = 0;
        list_head = 0;
        rst_n = 1'b0;

        add_item(OP_ALLOC, 0, 0);
        add_item(OP_FREE, 0, 16);
        add_item(OP_ALLOC, 24576, 0);
        add_item(OP_ALLOC, 1, 0);
        add_item(OP_ALLOC, 16, 0);
        add_item(OP_ALLOC, 17, 0);
        add_item(OP_ALLOC, 4080, 0);
        add_live_free();
        add_item(OP_FREE, 0, live_blocks[0] + 4);
        add_item(OP_FREE, 0, 24575);
        add_item(OP_FREE, 0, 8);
        add_item(OP_FREE, 0, freed_blocks[0]);
        add_item(OP_ALLOC, 12000, 0);
        add_item(OP_ALLOC, 24576, 0);
        add_live_free();
        add_live_free();
        add_item(OP_ALLOC, 30, 32767);
        add_item(OP_FREE, 32767, live_blocks[0]);
        void'(live_blocks.pop_front());

        n = pending_items.size();
        while (n < N_ITEMS)
        begin
            if (live_blocks.size() == 0 || $urandom_range(99) < (live_blocks.size() > 20 ? 30 : 55))
            begin
                add_item(OP_ALLOC, rand_size(), $urandom_range(32767));
            end
            else if ($urandom_range(99) < 85)
            begin
                add_live_free();
            end
            else
            begin
                add_bad_free();
            end
            n++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (checked_cnt >= N_ITEMS);
        repeat (100) @(posedge clk);
        $display("ran %0d items: %0d ok, %0d invalid, %0d out of memory; %0d responses checked",
                 N_ITEMS, n_ok, n_invalid, n_oom, checked_cnt);
        $display("long response stall taken while requests kept coming; %0d mismatches",
                 mismatch_cnt);
        if (mismatch_cnt == 0 && expected_rsp.size() == 0)
        begin
            $display("PASS free_list_heap_allocator");
        end
        else
        begin
            $display("FAIL free_list_heap_allocator");
        end
        $finish;
    end
endmodule
